@@ rtl/transformed_aabb_builder_macros.svh @@
// ----------------------------------------------------------------------------
// Transformed AABB builder assertion macros
// Concurrent check wrappers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef TRANSFORMED_AABB_BUILDER_MACROS_SVH
`define TRANSFORMED_AABB_BUILDER_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge out of reset
`define TAABB_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed");

// same-cycle implication
`define TAABB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication
`define TAABB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`else

`define TAABB_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define TAABB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define TAABB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/taabb_pkg.sv @@
// ----------------------------------------------------------------------------
// taabb_pkg
// Shared types and constants of the transformed AABB builder.
// ----------------------------------------------------------------------------
package taabb_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_IDX = 3'd5;

    // matrix entries are signed 32-bit fixed point
    localparam int MAT_W = 32;

    // reset values of the pair registers, indexed by matrix row
    localparam logic [2:0][CFG_DATA_W-1:0] PAIR_A_RST = {
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0001_0000
    };
    localparam logic [2:0][CFG_DATA_W-1:0] PAIR_B_RST = {
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000
    };

    // coordinate is split at this bit for the two partial products
    localparam int MUL_SPLIT = 24;

    // partial sums are clamped to +-2^62
    localparam logic signed [63:0] SUM_LIM     = 64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] NEG_SUM_LIM = -64'sh4000_0000_0000_0000;

    // axis / matrix column and row codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] LAST_CORNER = 3'd7;

    typedef struct packed {
        logic       vtx_load;   // fold accepted vertex into running box
        logic       run_clear;  // running box back to empty
        logic       box_init;   // transformed box back to empty
        logic       mul_en;     // launch partial products
        logic       acc_init;   // load translation into accumulator
        logic       sum_en;     // combine partial products
        logic       acc_en;     // add product into accumulator
        logic       fold_en;    // fold accumulator into transformed box
        logic       out_load;   // copy transformed box to output register
        logic [2:0] corner;
        logic [1:0] row;
        logic [1:0] col;
    } taabb_cmd_t;

endpackage

@@ rtl/taabb_ctrl.sv @@
// ----------------------------------------------------------------------------
// taabb_ctrl
// Sequencer: walks corners, rows and columns of the corner transform.
// ----------------------------------------------------------------------------
module taabb_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_last,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output taabb_pkg::taabb_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_FOLD = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] corner_reg, corner_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        corner_next    = corner_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;

        cmd          = '0;
        cmd.corner   = corner_reg;
        cmd.row      = row_reg;
        cmd.col      = col_reg;
        cmd.vtx_load = accept;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_last)
                begin
                    cmd.box_init = 1'b1;
                    corner_next  = '0;
                    row_next     = taabb_pkg::AXIS_X;
                    col_next     = taabb_pkg::AXIS_X;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.acc_init = (col_reg == taabb_pkg::AXIS_X);
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (col_reg == taabb_pkg::AXIS_Z)
                begin
                    col_next   = taabb_pkg::AXIS_X;
                    state_next = ST_FOLD;
                end
                else
                begin
                    col_next   = col_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_FOLD:
            begin
                cmd.fold_en = 1'b1;
                if (row_reg == taabb_pkg::AXIS_Z)
                begin
                    row_next = taabb_pkg::AXIS_X;
                    if (corner_reg == taabb_pkg::LAST_CORNER)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        corner_next = corner_reg + 3'd1;
                        state_next  = ST_MUL;
                    end
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.run_clear  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            corner_reg    <= '0;
            row_reg       <= taabb_pkg::AXIS_X;
            col_reg       <= taabb_pkg::AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            corner_reg    <= corner_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/taabb_dp.sv @@
// ----------------------------------------------------------------------------
// taabb_dp
// Datapath: matrix registers, running box, shared multiplier pair,
// accumulator and transformed box.
// ----------------------------------------------------------------------------
module taabb_dp
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  taabb_pkg::taabb_cmd_t                   cmd,
    input  logic                                    cfg_we,
    input  logic [taabb_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [taabb_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic signed [COORD_WIDTH-1:0]           pos_x,
    input  logic signed [COORD_WIDTH-1:0]           pos_y,
    input  logic signed [COORD_WIDTH-1:0]           pos_z,
    output logic signed [COORD_WIDTH-1:0]           box_min_x,
    output logic signed [COORD_WIDTH-1:0]           box_min_y,
    output logic signed [COORD_WIDTH-1:0]           box_min_z,
    output logic signed [COORD_WIDTH-1:0]           box_max_x,
    output logic signed [COORD_WIDTH-1:0]           box_max_y,
    output logic signed [COORD_WIDTH-1:0]           box_max_z
);

    localparam int SPLIT = taabb_pkg::MUL_SPLIT;
    localparam int MW    = taabb_pkg::MAT_W;
    localparam int A_EXT = (COORD_WIDTH > SPLIT + 1) ? COORD_WIDTH : SPLIT + 1;
    localparam int AH_W  = A_EXT - SPLIT;
    localparam int HI_W  = AH_W + MW;
    localparam int LO_W  = SPLIT + 1 + MW;
    localparam int SHIFT = SPLIT - FRAC_BITS;

    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [63:0] CMAX_W = 64'(CMAX);
    localparam logic signed [63:0] CMIN_W = 64'(CMIN);
    localparam logic signed [63:0] LIM_HI     = taabb_pkg::SUM_LIM >>> SHIFT;
    localparam logic signed [63:0] NEG_LIM_HI = -LIM_HI;
    localparam logic signed [64:0] ACC_LIM     = 65'(taabb_pkg::SUM_LIM);
    localparam logic signed [64:0] NEG_ACC_LIM = 65'(taabb_pkg::NEG_SUM_LIM);

    // matrix: pair_a = {m_r1, m_r0}, pair_b = {t_r, m_r2}
    logic [taabb_pkg::CFG_DATA_W-1:0] pair_a_reg [3];
    logic [taabb_pkg::CFG_DATA_W-1:0] pair_a_next [3];
    logic [taabb_pkg::CFG_DATA_W-1:0] pair_b_reg [3];
    logic [taabb_pkg::CFG_DATA_W-1:0] pair_b_next [3];

    logic signed [COORD_WIDTH-1:0] vtx [3];
    logic signed [COORD_WIDTH-1:0] run_min_reg [3];
    logic signed [COORD_WIDTH-1:0] run_min_next [3];
    logic signed [COORD_WIDTH-1:0] run_max_reg [3];
    logic signed [COORD_WIDTH-1:0] run_max_next [3];

    logic signed [COORD_WIDTH-1:0] box_lo_reg [3];
    logic signed [COORD_WIDTH-1:0] box_lo_next [3];
    logic signed [COORD_WIDTH-1:0] box_hi_reg [3];
    logic signed [COORD_WIDTH-1:0] box_hi_next [3];
    logic signed [COORD_WIDTH-1:0] out_min_reg [3];
    logic signed [COORD_WIDTH-1:0] out_min_next [3];
    logic signed [COORD_WIDTH-1:0] out_max_reg [3];
    logic signed [COORD_WIDTH-1:0] out_max_next [3];

    logic signed [MW-1:0]          m_sel;
    logic signed [MW-1:0]          t_sel;
    logic [taabb_pkg::CFG_DATA_W-1:0] row_a;
    logic [taabb_pkg::CFG_DATA_W-1:0] row_b;
    logic signed [COORD_WIDTH-1:0] p_sel;
    logic signed [A_EXT-1:0]       p_ext;
    logic signed [AH_W-1:0]        p_hi;
    logic signed [SPLIT:0]         p_lo;

    logic signed [HI_W-1:0] mul_hi_reg, mul_hi_next;
    logic signed [LO_W-1:0] mul_lo_reg, mul_lo_next;
    logic signed [LO_W-1:0] lo_sh;
    logic signed [63:0]     hi64, up64, lo64, part64;
    logic signed [63:0]     prod_reg, prod_next;
    logic signed [64:0]     acc_sum;
    logic signed [63:0]     acc_reg, acc_next;
    logic signed [COORD_WIDTH-1:0] acc_c;

    assign vtx[0] = pos_x;
    assign vtx[1] = pos_y;
    assign vtx[2] = pos_z;

    // configuration writes; indexes past the last register are dropped
    always_comb
    begin
        pair_a_next = pair_a_reg;
        pair_b_next = pair_b_reg;
        if (cfg_we && (cfg_addr <= taabb_pkg::CFG_LAST_IDX))
        begin
            if (cfg_addr[0])
                pair_b_next[cfg_addr[2:1]] = cfg_wdata;
            else
                pair_a_next[cfg_addr[2:1]] = cfg_wdata;
        end
    end

    // running per-axis min/max of the vertices
    always_comb
    begin
        run_min_next = run_min_reg;
        run_max_next = run_max_reg;
        for (int a = 0; a < 3; a++)
        begin
            if (cmd.run_clear)
            begin
                run_min_next[a] = CMAX;
                run_max_next[a] = CMIN;
            end
            else if (cmd.vtx_load)
            begin
                if (vtx[a] < run_min_reg[a])
                    run_min_next[a] = vtx[a];
                if (vtx[a] > run_max_reg[a])
                    run_max_next[a] = vtx[a];
            end
        end
    end

    // operand select: corner bit per axis picks max or min
    assign row_a = pair_a_reg[cmd.row];
    assign row_b = pair_b_reg[cmd.row];
    assign t_sel = row_b[2*MW-1:MW];

    always_comb
    begin
        case (cmd.col)
            taabb_pkg::AXIS_X: m_sel = row_a[MW-1:0];
            taabb_pkg::AXIS_Y: m_sel = row_a[2*MW-1:MW];
            default:           m_sel = row_b[MW-1:0];
        endcase
    end

    assign p_sel = cmd.corner[cmd.col] ? run_max_reg[cmd.col] : run_min_reg[cmd.col];
    assign p_ext = A_EXT'(p_sel);
    assign p_hi  = p_ext[A_EXT-1:SPLIT];
    assign p_lo  = {1'b0, p_ext[SPLIT-1:0]};

    // two partial products: floor(p / 2^24) * m and (p mod 2^24) * m
    assign mul_hi_next = p_hi * m_sel;
    assign mul_lo_next = p_lo * m_sel;

    // recombine, floor by the fraction bits, clamp to +-2^62
    assign hi64   = 64'(mul_hi_reg);
    assign up64   = hi64 <<< SHIFT;
    assign lo_sh  = mul_lo_reg >>> FRAC_BITS;
    assign lo64   = 64'(lo_sh);
    assign part64 = up64 + lo64;

    always_comb
    begin
        if (hi64 > LIM_HI)
            prod_next = taabb_pkg::SUM_LIM;
        else if (hi64 < NEG_LIM_HI)
            prod_next = taabb_pkg::NEG_SUM_LIM;
        else if (part64 > taabb_pkg::SUM_LIM)
            prod_next = taabb_pkg::SUM_LIM;
        else if (part64 < taabb_pkg::NEG_SUM_LIM)
            prod_next = taabb_pkg::NEG_SUM_LIM;
        else
            prod_next = part64;
    end

    // accumulator: translation first, then saturating adds
    assign acc_sum = 65'(acc_reg) + 65'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_init)
            acc_next = 64'(t_sel);
        else if (cmd.acc_en)
        begin
            if (acc_sum > ACC_LIM)
                acc_next = taabb_pkg::SUM_LIM;
            else if (acc_sum < NEG_ACC_LIM)
                acc_next = taabb_pkg::NEG_SUM_LIM;
            else
                acc_next = acc_sum[63:0];
        end
    end

    // saturate to the coordinate range and fold into the transformed box
    always_comb
    begin
        if (acc_reg > CMAX_W)
            acc_c = CMAX;
        else if (acc_reg < CMIN_W)
            acc_c = CMIN;
        else
            acc_c = acc_reg[COORD_WIDTH-1:0];
    end

    always_comb
    begin
        box_lo_next  = box_lo_reg;
        box_hi_next  = box_hi_reg;
        out_min_next = out_min_reg;
        out_max_next = out_max_reg;
        if (cmd.box_init)
        begin
            for (int a = 0; a < 3; a++)
            begin
                box_lo_next[a] = CMAX;
                box_hi_next[a] = CMIN;
            end
        end
        else if (cmd.fold_en)
        begin
            if (acc_c < box_lo_reg[cmd.row])
                box_lo_next[cmd.row] = acc_c;
            if (acc_c > box_hi_reg[cmd.row])
                box_hi_next[cmd.row] = acc_c;
        end
        if (cmd.out_load)
        begin
            out_min_next = box_lo_reg;
            out_max_next = box_hi_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                pair_a_reg[r]  <= taabb_pkg::PAIR_A_RST[r];
                pair_b_reg[r]  <= taabb_pkg::PAIR_B_RST[r];
                run_min_reg[r] <= CMAX;
                run_max_reg[r] <= CMIN;
            end
        end
        else
        begin
            pair_a_reg  <= pair_a_next;
            pair_b_reg  <= pair_b_next;
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            mul_hi_reg <= mul_hi_next;
            mul_lo_reg <= mul_lo_next;
        end
        if (cmd.sum_en)
            prod_reg <= prod_next;
        acc_reg     <= acc_next;
        box_lo_reg  <= box_lo_next;
        box_hi_reg  <= box_hi_next;
        out_min_reg <= out_min_next;
        out_max_reg <= out_max_next;
    end

    assign box_min_x = out_min_reg[0];
    assign box_min_y = out_min_reg[1];
    assign box_min_z = out_min_reg[2];
    assign box_max_x = out_max_reg[0];
    assign box_max_y = out_max_reg[1];
    assign box_max_z = out_max_reg[2];

endmodule

@@ rtl/transformed_aabb_builder.sv @@
// ----------------------------------------------------------------------------
// transformed_aabb_builder
// Running AABB of a vertex stream, emitted as the AABB of its eight corners
// after an affine transform.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one vertex per item, pos_x/y/z in signed
// fixed point, last marking the final vertex of a geometry. Ordinary vertices
// are taken one per cycle while no geometry is in flight and only widen the
// running box. On a last vertex the box is folded, then its eight corners go
// through the 3x4 matrix on one shared pair of multipliers: 24 corner rows of
// 3 products, each taken through multiply, sum and accumulate steps, with a
// fold step closing each row; the output register is then loaded once free,
// raising out_valid. in_ready stays low from the last vertex until that load.
// Output channel (out_valid/out_ready): one result item per geometry, held in
// an output register. While it waits the next geometry streams in; only the
// load of the following result waits for out_ready.
// Configuration: cfg_we writes cfg_wdata into matrix register cfg_addr at
// once; write only while no geometry is in flight.
// Reset: identity matrix, empty running box, no result pending.
// ----------------------------------------------------------------------------
`include "transformed_aabb_builder_macros.svh"

module transformed_aabb_builder
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // vertex channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_WIDTH-1:0]       pos_x,
    input  logic signed [COORD_WIDTH-1:0]       pos_y,
    input  logic signed [COORD_WIDTH-1:0]       pos_z,
    input  logic                                last,
    // box channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_WIDTH-1:0]       box_min_x,
    output logic signed [COORD_WIDTH-1:0]       box_min_y,
    output logic signed [COORD_WIDTH-1:0]       box_min_z,
    output logic signed [COORD_WIDTH-1:0]       box_max_x,
    output logic signed [COORD_WIDTH-1:0]       box_max_y,
    output logic signed [COORD_WIDTH-1:0]       box_max_z,
    // matrix register writes
    input  logic                                cfg_we,
    input  logic [taabb_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [taabb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    taabb_pkg::taabb_cmd_t cmd;

    // sequencer
    taabb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (last),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // arithmetic and storage
    taabb_dp
    #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .box_min_x (box_min_x),
        .box_min_y (box_min_y),
        .box_min_z (box_min_z),
        .box_max_x (box_max_x),
        .box_max_y (box_max_y),
        .box_max_z (box_max_z)
    );

    // no transform step runs while vertices are being taken
    `TAABB_ASSERT_IMPLIES(a_idle_no_math, clk, rst_n, in_ready, !(cmd.mul_en || cmd.sum_en || cmd.acc_en || cmd.fold_en || cmd.out_load))

    // at most one transform step per cycle
    `TAABB_ASSERT_ALWAYS(a_one_step, clk, rst_n, $onehot0({cmd.mul_en, cmd.sum_en, cmd.acc_en, cmd.fold_en, cmd.out_load}))

    // a last vertex starts the corner transform with the translation load
    `TAABB_ASSERT_NEXT(a_last_starts, clk, rst_n, in_valid && in_ready && last, cmd.mul_en && cmd.acc_init && !in_ready)

    // loading the result raises out_valid and reopens the input
    `TAABB_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid && in_ready)

endmodule
